// ===== sv/tjbm_pkg.sv =====
// ----------------------------------------------------------------------------
// Tick jitter bin monitor package
// Shared widths, register indexes, reset values and the small structs that
// pass between the front end, the statistics engine and the top level.
// ----------------------------------------------------------------------------
package tjbm_pkg;

	// Widths fixed by the item and result fields.
	localparam int TS_W      = 64;
	localparam int CNT_W     = 64;
	localparam int CFG_W     = 30;
	localparam int CFG_IDX_W = 1;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TARGET_PERIOD = 1'b0,
		REG_BIN_WIDTH     = 1'b1
	} cfg_reg_e;

	// Request kinds.
	localparam logic KIND_TICK   = 1'b0;
	localparam logic KIND_REPORT = 1'b1;

	// Register values after reset.
	localparam logic [CFG_W-1:0] TARGET_PERIOD_RST = 30'd250000;
	localparam logic [CFG_W-1:0] BIN_WIDTH_RST     = 30'd1000000;

	// Head of the request queue as seen by the engine.
	typedef struct packed {
		logic valid;
		logic report;
	} tjbm_head_t;

	// Current register settings.
	typedef struct packed {
		logic [CFG_W-1:0] target_period;
		logic [CFG_W-1:0] bin_width;
	} tjbm_cfg_t;

endpackage

// ===== sv/tjbm_ifs.sv =====
// ----------------------------------------------------------------------------
// Tick jitter bin monitor channels
// Valid/ready channels for tick and report requests, for report results and
// for configuration register writes.
// ----------------------------------------------------------------------------

// Incoming requests: tick events and report commands.
interface tjbm_in_if;
	import tjbm_pkg::*;
	logic            valid;
	logic            ready;
	logic            kind;
	logic [TS_W-1:0] timestamp_ns;
	logic            record_complete;
	modport source (output valid, kind, timestamp_ns, record_complete, input ready);
	modport sink   (input valid, kind, timestamp_ns, record_complete, output ready);
endinterface

// Outgoing period reports.
interface tjbm_out_if;
	import tjbm_pkg::*;
	logic             valid;
	logic             ready;
	logic [CNT_W-1:0] event_count;
	logic [CNT_W-1:0] bins_advanced;
	logic [CNT_W-1:0] peak_jitter_ns;
	modport source (output valid, event_count, bins_advanced, peak_jitter_ns, input ready);
	modport sink   (input valid, event_count, bins_advanced, peak_jitter_ns, output ready);
endinterface

// Configuration register writes.
interface tjbm_cfg_if;
	import tjbm_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_W-1:0]     data;
	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/tjbm_front.sv =====
// ----------------------------------------------------------------------------
// Tick jitter bin monitor front end
// Accepts requests, drops incomplete tick records and queues the rest in a
// two-entry queue for the statistics engine.
// ----------------------------------------------------------------------------
module tjbm_front #(
	parameter int TIME_WIDTH = 64
) (
	input  logic                   clk,
	input  logic                   arst_n,
	tjbm_in_if.sink                tick_in,
	output tjbm_pkg::tjbm_head_t   head,
	output logic [TIME_WIDTH-1:0]  head_ts,
	input  logic                   head_pop
);
	import tjbm_pkg::*;

	logic                  report_mem_q [2];
	logic [TIME_WIDTH-1:0] ts_mem_q     [2];
	logic                  wr_ptr_q;
	logic                  rd_ptr_q;
	logic [1:0]            count_q;
	logic                  accept;
	logic                  push;

	// A request is taken whenever the queue has room; incomplete ticks are dropped.
	assign tick_in.ready = (count_q != 2'd2);
	assign accept        = tick_in.valid && tick_in.ready;
	assign push          = accept && ((tick_in.kind == KIND_REPORT) || tick_in.record_complete);

	// Queue pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (head_pop) rd_ptr_q <= ~rd_ptr_q;
			if (push && !head_pop) begin
				count_q <= count_q + 2'd1;
			end else if (head_pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	// Queue payload.
	always_ff @(posedge clk) begin
		if (push) begin
			report_mem_q[wr_ptr_q] <= (tick_in.kind == KIND_REPORT);
			ts_mem_q[wr_ptr_q]     <= tick_in.timestamp_ns[TIME_WIDTH-1:0];
		end
	end

	assign head.valid  = (count_q != 2'd0);
	assign head.report = report_mem_q[rd_ptr_q];
	assign head_ts     = ts_mem_q[rd_ptr_q];

	// The engine never takes from an empty queue.
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		head_pop |-> head.valid)
		else $error("front: pop from empty queue");

	// A dropped tick leaves the fill level alone.
	a_drop_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !push && !head_pop) |=> $stable(count_q))
		else $error("front: incomplete tick changed queue level");

endmodule

// ===== sv/tjbm_div.sv =====
// ----------------------------------------------------------------------------
// Tick jitter bin monitor divider
// Restoring divider that produces one quotient bit per cycle; gives the bin
// index of a timestamp for the configured bin width.
// ----------------------------------------------------------------------------
module tjbm_div #(
	parameter int WIDTH = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [WIDTH-1:0]            dividend,
	input  logic [tjbm_pkg::CFG_W-1:0]  divisor,
	output logic                        busy,
	output logic                        done,
	output logic [WIDTH-1:0]            quotient
);
	import tjbm_pkg::*;

	localparam int CW = $clog2(WIDTH + 1);

	logic [CW-1:0]    cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [WIDTH-1:0] quo_q;
	logic [CFG_W-1:0] rem_q;
	logic [CFG_W:0]   rem_shift;
	logic [CFG_W:0]   rem_sub;
	logic             take;

	// One trial subtraction per cycle.
	always_comb begin
		rem_shift = {rem_q, quo_q[WIDTH-1]};
		rem_sub   = rem_shift - {1'b0, divisor};
		take      = (rem_shift >= {1'b0, divisor});
	end

	// Iteration control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q  <= CW'(WIDTH);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Partial remainder and quotient shift register.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= take ? rem_sub[CFG_W-1:0] : rem_shift[CFG_W-1:0];
			quo_q <= {quo_q[WIDTH-2:0], take};
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = quo_q;

	// A new division starts only when the previous one is over.
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> (!busy_q && !done_q))
		else $error("div: start while busy");

endmodule

// ===== sv/tjbm_back.sv =====
// ----------------------------------------------------------------------------
// Tick jitter bin monitor engine
// Takes queued requests in order, updates event count, jitter peak and bin
// advances for ticks, and loads the report register and clears the statistics for report requests.
// ----------------------------------------------------------------------------
module tjbm_back #(
	parameter int TIME_WIDTH = 64
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  tjbm_pkg::tjbm_cfg_t    cfg,
	input  tjbm_pkg::tjbm_head_t   head,
	input  logic [TIME_WIDTH-1:0]  head_ts,
	output logic                   head_pop,
	tjbm_out_if.source             report_out
);
	import tjbm_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_DEV  = 6'b000010,
		ST_PEAK = 6'b000100,
		ST_DIV  = 6'b001000,
		ST_BIN  = 6'b010000,
		ST_ACC  = 6'b100000
	} back_state_t;

	back_state_t           state_q;
	logic [CNT_W-1:0]      events_q;
	logic [CNT_W-1:0]      bins_q;
	logic [CNT_W-1:0]      peak_q;
	logic [TIME_WIDTH-1:0] prev_ts_q;
	logic [TIME_WIDTH-1:0] prev_bin_q;
	logic                  bin_known_q;
	logic [TIME_WIDTH-1:0] ts_q;
	logic [CNT_W-1:0]      gap_q;
	logic                  gap_ok_q;
	logic [CNT_W-1:0]      dev_q;
	logic [CNT_W-1:0]      diff_q;
	logic                  out_valid_q;
	logic [CNT_W-1:0]      out_events_q;
	logic [CNT_W-1:0]      out_bins_q;
	logic [CNT_W-1:0]      out_jitter_q;
	logic [CNT_W-1:0]      target;
	logic                  out_free;
	logic                  pop_report;
	logic                  pop_tick;
	logic                  div_start;
	logic                  div_busy;
	logic                  div_done;
	logic [TIME_WIDTH-1:0] bin;

	assign target     = CNT_W'(cfg.target_period);
	assign out_free   = !out_valid_q || report_out.ready;
	assign pop_report = (state_q == ST_IDLE) && head.valid && head.report && out_free;
	assign pop_tick   = (state_q == ST_IDLE) && head.valid && !head.report;
	assign head_pop   = pop_report || pop_tick;
	assign div_start  = (state_q == ST_PEAK) && (cfg.bin_width != '0);

	// Bin index of the current timestamp.
	tjbm_div #(
		.WIDTH (TIME_WIDTH)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (ts_q),
		.divisor  (cfg.bin_width),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (bin)
	);

	// Sequencer and period statistics.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			events_q    <= '0;
			bins_q      <= '0;
			peak_q      <= '0;
			prev_ts_q   <= '0;
			prev_bin_q  <= '0;
			bin_known_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (pop_report) begin
						events_q <= '0;
						bins_q   <= '0;
						peak_q   <= '0;
					end else if (pop_tick) begin
						events_q  <= events_q + CNT_W'(1);
						prev_ts_q <= head_ts;
						state_q   <= ST_DEV;
					end
				end
				ST_DEV: begin
					state_q <= ST_PEAK;
				end
				ST_PEAK: begin
					if (gap_ok_q && (dev_q > peak_q)) peak_q <= dev_q;
					state_q <= div_start ? ST_DIV : ST_IDLE;
				end
				ST_DIV: begin
					if (div_done) state_q <= ST_BIN;
				end
				ST_BIN: begin
					if (!bin_known_q) begin
						bin_known_q <= 1'b1;
						prev_bin_q  <= bin;
						state_q     <= ST_IDLE;
					end else if (bin != prev_bin_q) begin
						prev_bin_q <= bin;
						state_q    <= ST_ACC;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_ACC: begin
					bins_q  <= bins_q + diff_q;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Gap, deviation and bin difference, one wide subtraction per cycle.
	always_ff @(posedge clk) begin
		if (pop_tick) begin
			ts_q     <= head_ts;
			gap_q    <= CNT_W'(head_ts) - CNT_W'(prev_ts_q);
			gap_ok_q <= (prev_ts_q != '0);
		end
		if (state_q == ST_DEV) begin
			dev_q <= (gap_q > target) ? (gap_q - target) : (target - gap_q);
		end
		if (state_q == ST_BIN) begin
			diff_q <= CNT_W'(bin) - CNT_W'(prev_bin_q);
		end
	end

	// Report output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop_report) begin
			out_valid_q <= 1'b1;
		end else if (report_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop_report) begin
			out_events_q <= events_q;
			out_bins_q   <= bins_q;
			out_jitter_q <= peak_q;
		end
	end

	assign report_out.valid          = out_valid_q;
	assign report_out.event_count    = out_events_q;
	assign report_out.bins_advanced  = out_bins_q;
	assign report_out.peak_jitter_ns = out_jitter_q;

	// Requests are taken only between ticks.
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		head_pop |-> (state_q == ST_IDLE))
		else $error("back: request taken while busy");

	// While waiting on the divider it is either running or just finished.
	a_div_alive: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (div_busy || div_done))
		else $error("back: waiting on an idle divider");

	// A pending report is never overwritten.
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !report_out.ready) |-> !pop_report)
		else $error("back: report overwritten");

endmodule

// ===== sv/tick_jitter_bin_monitor.sv =====
// ----------------------------------------------------------------------------
// Tick jitter bin monitor
// Per-period statistics over tick timestamps: event count, jitter peak and
// bin advances, read out and cleared by a report request.
// ----------------------------------------------------------------------------
// A tick request with a complete record counts one event, updates the largest
// |gap - target_period_ns| (no gap is taken while the previous timestamp is
// zero) and, when bin_width_ns is nonzero, the number of bins advanced; only
// the low TIME_WIDTH bits of the timestamp are used and all differences wrap
// at 64 bits. A report request returns the three figures and clears them.
// Requests are queued two deep and handled one at a time in order: a tick
// passes through the ST_DEV and ST_PEAK states and, with binning on, waits in
// ST_DIV on the one-bit-per-cycle bin divider, then ST_BIN and, when the bin
// index moves, ST_ACC; a report is taken in the idle state once the result
// register is free. Register writes take effect at once and are meant for
// idle periods.
module tick_jitter_bin_monitor #(
	parameter int TIME_WIDTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	tjbm_in_if.sink     tick_in,
	tjbm_out_if.source  report_out,
	tjbm_cfg_if.sink    cfg
);
	import tjbm_pkg::*;

	tjbm_cfg_t             cfg_q;
	tjbm_head_t            head;
	logic [TIME_WIDTH-1:0] head_ts;
	logic                  head_pop;

	// Configuration registers; writes are always taken.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.target_period <= TARGET_PERIOD_RST;
			cfg_q.bin_width     <= BIN_WIDTH_RST;
		end else if (cfg.valid) begin
			unique case (cfg_reg_e'(cfg.index))
				REG_TARGET_PERIOD: cfg_q.target_period <= cfg.data;
				REG_BIN_WIDTH:     cfg_q.bin_width     <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	// Request intake and queue.
	tjbm_front #(
		.TIME_WIDTH (TIME_WIDTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.tick_in  (tick_in),
		.head     (head),
		.head_ts  (head_ts),
		.head_pop (head_pop)
	);

	// Statistics engine and report register.
	tjbm_back #(
		.TIME_WIDTH (TIME_WIDTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.head       (head),
		.head_ts    (head_ts),
		.head_pop   (head_pop),
		.report_out (report_out)
	);

endmodule
